>>> src/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types, byte codes and the CRC-16-CCITT byte update for the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

    localparam int unsigned MaxBodyDefault = 1024;

    // Link control bytes.
    localparam logic [7:0] ByteStart  = 8'hFC;
    localparam logic [7:0] ByteEnd    = 8'hFD;
    localparam logic [7:0] ByteEscape = 8'hFE;
    localparam logic [7:0] EscapeMask = 8'h20;
    localparam logic [15:0] CrcInit   = 16'hFFFF;

    // Frame status codes.
    localparam logic [2:0] StatusOk       = 3'd0;
    localparam logic [2:0] StatusCrcError = 3'd1;
    localparam logic [2:0] StatusShort    = 3'd2;
    localparam logic [2:0] StatusFraming  = 3'd3;
    localparam logic [2:0] StatusOverflow = 3'd4;

    typedef enum logic [2:0] {
        PH_HUNT = 3'b001,
        PH_BODY = 3'b010,
        PH_ESC  = 3'b100
    } t_phase;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [9:0]  byte_index;
        logic        frame_end;
        logic [2:0]  status;
        logic [7:0]  packet_number;
        logic [15:0] packet_code;
        logic [9:0]  payload_length;
    } t_result;

    // Byte-wise CCITT update, low byte swapped into the high position first.
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] x);
        logic [15:0] c;
        c = {crc[7:0], crc[15:8]} ^ {8'h00, x};
        c = c ^ {12'h000, c[7:4]};
        c = c ^ {c[3:0], 12'h000};
        c = c ^ {3'b000, c[7:0], 5'b00000};
        return c;
    endfunction

endpackage

`default_nettype wire

>>> src/stuffed_frame_deframer_crc16.sv
// ----------------------------------------------------------------------------
// stuffed_frame_deframer_crc16
// Byte-stuffed frame deframer with CRC-16-CCITT check.
// ----------------------------------------------------------------------------
// Takes one received byte per request and returns at most one result per
// byte: a payload byte with its index, or a frame-end result with packet
// number, packet code, payload length and status. A byte passes through an
// input register, goes through combinational unstuffing and CRC logic, and
// lands in a result register, so a new byte is taken every cycle while the
// consumer keeps up. Backpressure on the result side stalls the input
// register and then the input channel. Bodies longer than MAX_BODY bytes are
// flagged as overflow.
`default_nettype none

module stuffed_frame_deframer_crc16 #(
    parameter int unsigned MAX_BODY = sfd_pkg::MaxBodyDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_data_byte,
    output logic [9:0]       o_byte_index,
    output logic             o_frame_end,
    output logic [2:0]       o_status,
    output logic [7:0]       o_packet_number,
    output logic [15:0]      o_packet_code,
    output logic [9:0]       o_payload_length
);

    logic             r_in_valid, n_in_valid;
    logic [7:0]       r_in_byte;
    logic             out_free;
    logic             step;
    logic             res_valid;
    sfd_pkg::t_result res;
    sfd_pkg::t_result out_res;

    assign step       = r_in_valid && out_free;
    assign o_ready    = !r_in_valid || out_free;
    assign n_in_valid = (i_valid && o_ready) || (r_in_valid && !out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    sfd_core #(
        .MAX_BODY(MAX_BODY)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_byte     (r_in_byte),
        .o_res      (res),
        .o_res_valid(res_valid)
    );

    sfd_out_stage u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (res_valid),
        .i_res  (res),
        .i_ready(i_ready),
        .o_valid(o_valid),
        .o_free (out_free),
        .o_res  (out_res)
    );

    assign o_data_byte      = out_res.data_byte;
    assign o_byte_index     = out_res.byte_index;
    assign o_frame_end      = out_res.frame_end;
    assign o_status         = out_res.status;
    assign o_packet_number  = out_res.packet_number;
    assign o_packet_code    = out_res.packet_code;
    assign o_payload_length = out_res.payload_length;

endmodule

`default_nettype wire

>>> src/sfd_core.sv
// ----------------------------------------------------------------------------
// sfd_core
// Frame state, unstuffing, header capture, CRC hold and result formation.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_core #(
    parameter int unsigned MAX_BODY = sfd_pkg::MaxBodyDefault
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire logic [7:0]      i_byte,
    output sfd_pkg::t_result     o_res,
    output logic                 o_res_valid
);

    localparam int unsigned CW = $clog2(MAX_BODY + 1);
    localparam int unsigned XW = (CW > 10) ? CW : 10;

    sfd_pkg::t_phase r_phase, n_phase;
    logic [7:0]      r_hold0, n_hold0;
    logic [7:0]      r_hold1, n_hold1;
    logic [15:0]     r_crc, n_crc;
    logic [CW-1:0]   r_count, n_count;
    logic [7:0]      r_number, n_number;
    logic [15:0]     r_code, n_code;
    logic            r_overflow, n_overflow;

    logic [7:0]      body_byte;
    logic [XW-1:0]   count_ext;
    logic [XW-1:0]   count_less5;
    logic [9:0]      length;
    logic [2:0]      end_status;

    assign count_ext   = XW'(r_count);
    assign count_less5 = count_ext - XW'(5);
    assign length      = (r_count >= CW'(5)) ? count_less5[9:0] : 10'd0;
    assign body_byte   = (r_phase == sfd_pkg::PH_ESC) ? (i_byte ^ sfd_pkg::EscapeMask) : i_byte;

    always_comb begin
        if (r_overflow) begin
            end_status = sfd_pkg::StatusOverflow;
        end else if (r_count < CW'(5)) begin
            end_status = sfd_pkg::StatusShort;
        end else if (r_hold0 == r_crc[7:0] && r_hold1 == r_crc[15:8]) begin
            end_status = sfd_pkg::StatusOk;
        end else begin
            end_status = sfd_pkg::StatusCrcError;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_hold0    = r_hold0;
        n_hold1    = r_hold1;
        n_crc      = r_crc;
        n_count    = r_count;
        n_number   = r_number;
        n_code     = r_code;
        n_overflow = r_overflow;

        o_res_valid          = 1'b0;
        o_res                = '0;
        o_res.packet_number  = r_number;
        o_res.packet_code    = r_code;
        o_res.payload_length = length;

        if (i_step) begin
            case (r_phase)
                sfd_pkg::PH_HUNT: begin
                    if (i_byte == sfd_pkg::ByteStart) begin
                        n_hold0    = '0;
                        n_hold1    = '0;
                        n_crc      = sfd_pkg::CrcInit;
                        n_count    = '0;
                        n_number   = '0;
                        n_code     = '0;
                        n_overflow = 1'b0;
                        n_phase    = sfd_pkg::PH_BODY;
                    end
                end
                default: begin
                    if (i_byte == sfd_pkg::ByteStart) begin
                        // A start byte inside a frame closes it and opens the next.
                        o_res_valid     = 1'b1;
                        o_res.frame_end = 1'b1;
                        o_res.status    = sfd_pkg::StatusFraming;
                        n_hold0    = '0;
                        n_hold1    = '0;
                        n_crc      = sfd_pkg::CrcInit;
                        n_count    = '0;
                        n_number   = '0;
                        n_code     = '0;
                        n_overflow = 1'b0;
                        n_phase    = sfd_pkg::PH_BODY;
                    end else if (i_byte == sfd_pkg::ByteEnd) begin
                        o_res_valid     = 1'b1;
                        o_res.frame_end = 1'b1;
                        o_res.status    = end_status;
                        n_phase         = sfd_pkg::PH_HUNT;
                    end else if (r_phase == sfd_pkg::PH_BODY && i_byte == sfd_pkg::ByteEscape) begin
                        n_phase = sfd_pkg::PH_ESC;
                    end else begin
                        n_phase = sfd_pkg::PH_BODY;
                        if (r_count >= CW'(MAX_BODY)) begin
                            n_overflow = 1'b1;
                        end else begin
                            n_count = r_count + CW'(1);
                            if (r_count == CW'(0)) begin
                                n_number = body_byte;
                                n_crc    = sfd_pkg::crc_update(r_crc, body_byte);
                            end else if (r_count == CW'(1)) begin
                                n_code[7:0] = body_byte;
                                n_crc       = sfd_pkg::crc_update(r_crc, body_byte);
                            end else if (r_count == CW'(2)) begin
                                n_code[15:8] = body_byte;
                                n_crc        = sfd_pkg::crc_update(r_crc, body_byte);
                            end else if (r_count == CW'(3)) begin
                                n_hold0 = body_byte;
                            end else if (r_count == CW'(4)) begin
                                n_hold1 = body_byte;
                            end else begin
                                // The oldest held byte is payload once two newer ones exist.
                                n_crc   = sfd_pkg::crc_update(r_crc, r_hold0);
                                n_hold0 = r_hold1;
                                n_hold1 = body_byte;
                                o_res_valid          = 1'b1;
                                o_res.data_byte      = r_hold0;
                                o_res.byte_index     = count_less5[9:0];
                                o_res.payload_length = 10'd0;
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= sfd_pkg::PH_HUNT;
            r_hold0    <= '0;
            r_hold1    <= '0;
            r_crc      <= sfd_pkg::CrcInit;
            r_count    <= '0;
            r_number   <= '0;
            r_code     <= '0;
            r_overflow <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_hold0    <= n_hold0;
            r_hold1    <= n_hold1;
            r_crc      <= n_crc;
            r_count    <= n_count;
            r_number   <= n_number;
            r_code     <= n_code;
            r_overflow <= n_overflow;
        end
    end

endmodule

`default_nettype wire

>>> src/sfd_out_stage.sv
// ----------------------------------------------------------------------------
// sfd_out_stage
// Result register with valid/ready toward the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_out_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire sfd_pkg::t_result  i_res,
    input  wire logic              i_ready,
    output logic                   o_valid,
    output logic                   o_free,
    output sfd_pkg::t_result       o_res
);

    logic             r_valid, n_valid;
    sfd_pkg::t_result r_res;

    // The slot can take a new result when empty or when its request leaves now.
    assign o_free  = !r_valid || i_ready;
    assign n_valid = i_load || (r_valid && !i_ready);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

>>> verif/tb_stuffed_frame_deframer_crc16.sv
// ----------------------------------------------------------------------------
// tb_stuffed_frame_deframer_crc16
// Self-checking bench for the byte-stuffed frame deframer with CRC-16 check.
// ----------------------------------------------------------------------------
// A short table of hand-picked link bytes runs first. It covers bytes ignored
// while hunting, short frames, a start byte inside a frame, an end byte after
// an escape, and escaped control bytes. Random frames follow. Most of them
// carry a correct CRC. The rest have a bad CRC or are cut short, truncated or
// closed right after an escape. A behavioral deframer predicts the random
// frames and some table rows; the other rows give their own expectation.
// Results are compared field by field in order of arrival. Both sides of the
// link idle at random, and the consumer once holds off till the input stalls.
// ----------------------------------------------------------------------------
module tb_stuffed_frame_deframer_crc16;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MaxBody = sfd_pkg::MaxBodyDefault;
    localparam logic [15:0] CrcPoly = 16'h1021;

    // How a stimulus row supplies its expectation.
    localparam int UsePredictor = -1;
    localparam int NoResult     = 0;
    localparam int OneResult    = 1;

    typedef enum {
        FrameGood,
        FrameBadCrc,
        FrameShort,
        FrameCut,
        FrameEscEnd
    } t_frame_kind;

    typedef struct {
        logic [7:0]       rx;
        int               typed_cnt;
        sfd_pkg::t_result typed;
    } t_dir_row;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  in_byte   = 8'h00;
    logic        out_ready = 1'b0;
    logic        dut_ready;
    logic        out_valid;
    wire sfd_pkg::t_result got;
    sfd_pkg::t_result      want;

    sfd_pkg::t_result deframed_q[$];
    logic [7:0]  link_q[$];
    t_dir_row    dir_rows[24];
    int          fail_count    = 0;
    int          send_idle_pct = 28;
    int          recv_idle_pct = 49;
    int          hold_left     = 0;

    // Predictor state.
    sfd_pkg::t_phase link_phase = sfd_pkg::PH_HUNT;
    logic [7:0]  held[2]    = '{8'h00, 8'h00};
    logic [15:0] crc_acc    = sfd_pkg::CrcInit;
    int unsigned body_cnt   = 0;
    logic [7:0]  pkt_num    = 8'h00;
    logic [15:0] pkt_code   = 16'h0000;
    logic        overflowed = 1'b0;

    stuffed_frame_deframer_crc16 #(
        .MAX_BODY(MaxBody)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (in_valid),
        .o_ready         (dut_ready),
        .i_rx_byte       (in_byte),
        .o_valid         (out_valid),
        .i_ready         (out_ready),
        .o_data_byte     (got.data_byte),
        .o_byte_index    (got.byte_index),
        .o_frame_end     (got.frame_end),
        .o_status        (got.status),
        .o_packet_number (got.packet_number),
        .o_packet_code   (got.packet_code),
        .o_payload_length(got.payload_length)
    );

    always #2 clk = ~clk;

    // Bit-serial CCITT polynomial, MSB first.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        int k;
        c = crc ^ {b, 8'h00};
        for (k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
        end
        return c;
    endfunction

    function automatic void clear_frame();
        held[0]    = 8'h00;
        held[1]    = 8'h00;
        crc_acc    = sfd_pkg::CrcInit;
        body_cnt   = 0;
        pkt_num    = 8'h00;
        pkt_code   = 16'h0000;
        overflowed = 1'b0;
    endfunction

    function automatic sfd_pkg::t_result frame_end_result(input logic [2:0] st);
        sfd_pkg::t_result r;
        int unsigned len;
        len = (body_cnt >= 5) ? body_cnt - 5 : 0;
        r = '0;
        r.frame_end      = 1'b1;
        r.status         = st;
        r.packet_number  = pkt_num;
        r.packet_code    = pkt_code;
        r.payload_length = 10'(len);
        return r;
    endfunction

    // Advances the predictor by one link byte; returns 1 when a result leaves.
    function automatic bit deframe_byte(input logic [7:0] rx,
                                        output sfd_pkg::t_result res);
        logic [7:0] b;
        int unsigned n;
        b = rx;
        res = '0;
        if (link_phase == sfd_pkg::PH_HUNT) begin
            if (b == sfd_pkg::ByteStart) begin
                clear_frame();
                link_phase = sfd_pkg::PH_BODY;
            end
            return 0;
        end
        if (b == sfd_pkg::ByteStart) begin
            res = frame_end_result(sfd_pkg::StatusFraming);
            clear_frame();
            link_phase = sfd_pkg::PH_BODY;
            return 1;
        end
        if (b == sfd_pkg::ByteEnd) begin
            if (overflowed)
                res = frame_end_result(sfd_pkg::StatusOverflow);
            else if (body_cnt < 5)
                res = frame_end_result(sfd_pkg::StatusShort);
            else if (held[0] == crc_acc[7:0] && held[1] == crc_acc[15:8])
                res = frame_end_result(sfd_pkg::StatusOk);
            else
                res = frame_end_result(sfd_pkg::StatusCrcError);
            link_phase = sfd_pkg::PH_HUNT;
            return 1;
        end
        if (link_phase == sfd_pkg::PH_BODY && b == sfd_pkg::ByteEscape) begin
            link_phase = sfd_pkg::PH_ESC;
            return 0;
        end
        if (link_phase == sfd_pkg::PH_ESC)
            b = b ^ sfd_pkg::EscapeMask;
        link_phase = sfd_pkg::PH_BODY;
        if (body_cnt >= MaxBody) begin
            overflowed = 1'b1;
            return 0;
        end
        n = body_cnt;
        body_cnt = n + 1;
        case (n)
            0: begin
                pkt_num = b;
                crc_acc = crc_step(crc_acc, b);
            end
            1: begin
                pkt_code[7:0] = b;
                crc_acc = crc_step(crc_acc, b);
            end
            2: begin
                pkt_code[15:8] = b;
                crc_acc = crc_step(crc_acc, b);
            end
            3: held[0] = b;
            4: held[1] = b;
            default: begin
                // The oldest held byte is now known not to be CRC, so it leaves.
                res.data_byte     = held[0];
                res.byte_index    = 10'(n - 5);
                res.packet_number = pkt_num;
                res.packet_code   = pkt_code;
                crc_acc = crc_step(crc_acc, held[0]);
                held[0] = held[1];
                held[1] = b;
                return 1;
            end
        endcase
        return 0;
    endfunction

    function automatic sfd_pkg::t_result short_end(input logic [2:0] st,
                                                   input logic [7:0] num);
        sfd_pkg::t_result r;
        r = '0;
        r.frame_end     = 1'b1;
        r.status        = st;
        r.packet_number = num;
        return r;
    endfunction

    function automatic string show(input sfd_pkg::t_result r);
        return $sformatf("data=%h idx=%0d end=%0b st=%0d num=%h code=%h len=%0d",
                         r.data_byte, r.byte_index, r.frame_end, r.status,
                         r.packet_number, r.packet_code, r.payload_length);
    endfunction

    task automatic report_fail(input string what, input sfd_pkg::t_result exp_r,
                               input sfd_pkg::t_result got_r);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t ns: %s", $realtime, what);
            $display("  expected %s", show(exp_r));
            $display("  actual   %s", show(got_r));
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (deframed_q.size() == 0) begin
                report_fail("result with nothing expected", '0, got);
            end else begin
                want = deframed_q.pop_front();
                if (got.data_byte !== want.data_byte || got.byte_index !== want.byte_index
                    || got.frame_end !== want.frame_end || got.status !== want.status
                    || got.packet_number !== want.packet_number
                    || got.packet_code !== want.packet_code
                    || got.payload_length !== want.payload_length)
                    report_fail("result mismatch", want, got);
            end
        end
    end

    // Consumer side: random stalls, plus a long hold-off when one is requested.
    initial begin
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
            @(posedge clk);
        end
    end

    task automatic send_byte(input logic [7:0] b, input int typed_cnt,
                             input sfd_pkg::t_result typed);
        sfd_pkg::t_result res;
        bit emits;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do @(posedge clk); while (!dut_ready);
        emits = deframe_byte(b, res);
        if (typed_cnt == UsePredictor) begin
            if (emits)
                deframed_q.push_back(res);
        end else if (typed_cnt == OneResult) begin
            deframed_q.push_back(typed);
        end
    endtask

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(3) == 0) begin
            case ($urandom_range(4))
                0: return sfd_pkg::ByteStart;
                1: return sfd_pkg::ByteEnd;
                2: return sfd_pkg::ByteEscape;
                3: return 8'h00;
                default: return 8'hFF;
            endcase
        end
        return 8'($urandom_range(255));
    endfunction

    // Control bytes must be escaped; any other byte may be, unless its escaped
    // form would itself read as a start or end byte.
    function automatic void push_stuffed(input logic [7:0] b);
        logic [7:0] alt;
        alt = b ^ sfd_pkg::EscapeMask;
        if (b == sfd_pkg::ByteStart || b == sfd_pkg::ByteEnd || b == sfd_pkg::ByteEscape
            || (alt != sfd_pkg::ByteStart && alt != sfd_pkg::ByteEnd
                && $urandom_range(15) == 0)) begin
            link_q.push_back(sfd_pkg::ByteEscape);
            link_q.push_back(alt);
        end else begin
            link_q.push_back(b);
        end
    endfunction

    function automatic void queue_frame(input t_frame_kind kind, input int pay_len);
        logic [7:0] body[$];
        logic [15:0] crc;
        int keep;
        int k;
        for (k = 0; k < pay_len + 3; k++)
            body.push_back(pick_byte());
        crc = sfd_pkg::CrcInit;
        foreach (body[j])
            crc = crc_step(crc, body[j]);
        if (kind == FrameBadCrc)
            crc = crc ^ (16'h0001 << $urandom_range(15));
        body.push_back(crc[7:0]);
        body.push_back(crc[15:8]);
        keep = body.size();
        if (kind == FrameShort)
            keep = $urandom_range(4);
        else if (kind == FrameCut)
            keep = $urandom_range(body.size());
        link_q.push_back(sfd_pkg::ByteStart);
        for (k = 0; k < keep; k++)
            push_stuffed(body[k]);
        if (kind == FrameEscEnd)
            link_q.push_back(sfd_pkg::ByteEscape);
        if (kind != FrameCut)
            link_q.push_back(sfd_pkg::ByteEnd);
    endfunction

    task automatic send_queued();
        while (link_q.size() > 0)
            send_byte(link_q.pop_front(), UsePredictor, '0);
    endtask

    task automatic run_random_frames(input int n_bytes);
        int sent_here;
        int roll;
        t_frame_kind kind;
        sent_here = 0;
        while (sent_here < n_bytes) begin
            roll = $urandom_range(99);
            if (roll < 62)
                kind = FrameGood;
            else if (roll < 74)
                kind = FrameBadCrc;
            else if (roll < 84)
                kind = FrameShort;
            else if (roll < 93)
                kind = FrameCut;
            else
                kind = FrameEscEnd;
            queue_frame(kind, ($urandom_range(7) == 0) ? $urandom_range(40)
                                                       : $urandom_range(10));
            // Line noise between frames.
            repeat ($urandom_range(2))
                link_q.push_back(8'($urandom_range(255)));
            sent_here += link_q.size();
            send_queued();
        end
    endtask

    initial begin
        int row;
        dir_rows = '{
            '{8'h00, NoResult, '0},
            '{sfd_pkg::ByteEnd, NoResult, '0},
            '{sfd_pkg::ByteEscape, NoResult, '0},
            '{sfd_pkg::ByteStart, NoResult, '0},
            '{sfd_pkg::ByteEnd, OneResult, short_end(sfd_pkg::StatusShort, 8'h00)},
            '{sfd_pkg::ByteStart, NoResult, '0},
            '{8'hFF, UsePredictor, '0},
            '{sfd_pkg::ByteStart, OneResult, short_end(sfd_pkg::StatusFraming, 8'hFF)},
            '{8'h00, UsePredictor, '0},
            '{sfd_pkg::ByteEscape, UsePredictor, '0},
            '{sfd_pkg::ByteEnd, OneResult, short_end(sfd_pkg::StatusShort, 8'h00)},
            '{sfd_pkg::ByteStart, NoResult, '0},
            '{8'h12, UsePredictor, '0},
            '{8'h34, UsePredictor, '0},
            '{sfd_pkg::ByteEscape, UsePredictor, '0},
            '{8'hDE, UsePredictor, '0},
            '{sfd_pkg::ByteEscape, UsePredictor, '0},
            '{sfd_pkg::ByteEscape, UsePredictor, '0},
            '{sfd_pkg::ByteEscape, UsePredictor, '0},
            '{8'hDC, UsePredictor, '0},
            '{8'hFF, UsePredictor, '0},
            '{8'h00, UsePredictor, '0},
            '{8'hAA, UsePredictor, '0},
            '{sfd_pkg::ByteEnd, UsePredictor, '0}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < $size(dir_rows); row++)
            send_byte(dir_rows[row].rx, dir_rows[row].typed_cnt, dir_rows[row].typed);

        run_random_frames(300);

        send_idle_pct = 49;
        recv_idle_pct = 28;
        run_random_frames(300);

        // No idling from here on; the consumer first holds off while requests
        // keep coming, so the block has to stall its input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = 90;
        run_random_frames(300);
        in_valid <= 1'b0;

        while (deframed_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
src/sfd_pkg.sv
src/sfd_core.sv
src/sfd_out_stage.sv
src/stuffed_frame_deframer_crc16.sv
verif/tb_stuffed_frame_deframer_crc16.sv
